@@ rtl/sss_pkg.sv @@
`default_nettype none

package sss_pkg;

   // Fixed field widths of the transaction payloads and the target register.
   localparam int TARGET_W     = 21;
   localparam int ELEM_FIELD_W = 16;
   localparam int COUNT_W      = 17;
   localparam int MASK_W       = 16;

   // Saturation value of the match counter.
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // One walk step as it leaves the step generator, aligned with the store read data.
   typedef struct packed {
      logic valid;
      logic subtract;
   } step_type;

   // Control from the sequencer to the accumulator.
   typedef struct packed {
      logic clear;
      logic load;
      logic start;
   } accum_ctl_type;

endpackage

`default_nettype wire

@@ rtl/sss_req_if.sv @@
`default_nettype none

interface sss_req_if;
   import sss_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [ELEM_FIELD_W-1:0] element_value;
   logic                           last_element;

   modport source (output valid, output element_value, output last_element, input ready);
   modport sink   (input valid, input element_value, input last_element, output ready);

endinterface

`default_nettype wire

@@ rtl/sss_rsp_if.sv @@
`default_nettype none

interface sss_rsp_if;
   import sss_pkg::*;

   logic               valid;
   logic               ready;
   logic               found;
   logic [COUNT_W-1:0] match_count;
   logic [MASK_W-1:0]  subset_mask;
   logic               overflow;

   modport source (output valid, output found, output match_count, output subset_mask,
                   output overflow, input ready);
   modport sink   (input valid, input found, input match_count, input subset_mask,
                   input overflow, output ready);

endinterface

`default_nettype wire

@@ rtl/sss_elem_store.sv @@
`default_nettype none

module sss_elem_store
   import sss_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/sss_step_gen.sv @@
`default_nettype none

module sss_step_gen
   import sss_pkg::*;
#(
   parameter int MAX_ELEMENTS = 16,
   parameter int CNT_W        = 5,
   parameter int ADDR_W       = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [CNT_W-1:0]        elem_count,
   output logic      [ADDR_W-1:0]       rd_addr,
   output logic                         active,
   output step_type                     step,
   output logic      [MAX_ELEMENTS-1:0] leaf
);

   localparam int STEP_W = MAX_ELEMENTS + 1;

   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    active_ff, active_in;
   step_type                step_out_ff, step_out_in;
   logic [MAX_ELEMENTS-1:0] leaf_ff, leaf_in;

   logic [STEP_W-1:0]       leaves;
   logic                    last_step;
   logic [MAX_ELEMENTS-1:0] t;
   logic [MAX_ELEMENTS-1:0] low_bit;
   logic [ADDR_W-1:0]       flip_pos;

   // Gray-code walk: step t flips the leaf bit at the lowest set bit of t.
   always_comb begin
      leaves    = STEP_W'(1) << elem_count;
      last_step = (step_ff == (leaves - STEP_W'(1)));
      t         = step_ff[MAX_ELEMENTS-1:0];
      low_bit   = t & (~t + MAX_ELEMENTS'(1));
      flip_pos  = '0;
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         if (low_bit[i]) begin
            flip_pos = flip_pos | ADDR_W'(i);
         end
      end
      // Leaf bit b belongs to element N-1-b.
      rd_addr = ADDR_W'(elem_count - CNT_W'(1) - CNT_W'(flip_pos));
   end

   // Step counter and the registered step that meets the store read data.
   always_comb begin
      step_in              = step_ff;
      active_in            = active_ff;
      step_out_in.valid    = active_ff;
      // A leaf bit that turns to one drops its element from the subset.
      step_out_in.subtract = ~|(t & (low_bit << 1));
      leaf_in              = t ^ (t >> 1);
      if (start) begin
         step_in   = STEP_W'(1);
         active_in = 1'b1;
      end else if (active_ff) begin
         step_in = step_ff + STEP_W'(1);
         if (last_step) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff           <= '0;
         active_ff         <= 1'b0;
         step_out_ff.valid <= 1'b0;
      end else begin
         step_ff           <= step_in;
         active_ff         <= active_in;
         step_out_ff.valid <= step_out_in.valid;
      end
      step_out_ff.subtract <= step_out_in.subtract;
      leaf_ff              <= leaf_in;
   end

   assign active = active_ff;
   assign step   = step_out_ff;
   assign leaf   = leaf_ff;

endmodule

`default_nettype wire

@@ rtl/sss_accum.sv @@
`default_nettype none

module sss_accum
   import sss_pkg::*;
#(
   parameter int ELEMENT_WIDTH = 16,
   parameter int MAX_ELEMENTS  = 16,
   parameter int SUM_W         = 21
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire accum_ctl_type               ctl,
   input  wire logic [ELEMENT_WIDTH-1:0]    load_data,
   input  wire logic [ELEMENT_WIDTH-1:0]    rd_data,
   input  wire step_type                    step,
   input  wire logic [MAX_ELEMENTS-1:0]     leaf,
   input  wire logic signed [TARGET_W-1:0]  target,
   output logic                             busy,
   output logic      [COUNT_W-1:0]          match_count,
   output logic      [MAX_ELEMENTS-1:0]     best_leaf
);

   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic                    cmp_valid_ff, cmp_valid_in;
   logic [MAX_ELEMENTS-1:0] cmp_leaf_ff, cmp_leaf_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [MAX_ELEMENTS-1:0] best_ff, best_in;

   logic [ELEMENT_WIDTH-1:0] op_raw;
   logic [SUM_W-1:0]         op_ext;
   logic                     subtract;
   logic [SUM_W-1:0]         sum_next;
   logic [SUM_W-1:0]         target_ext;
   logic                     hit;

   // Shared add/subtract unit: loads build the full-set sum, walk steps adjust it.
   always_comb begin
      op_raw   = step.valid ? rd_data : load_data;
      op_ext   = {{(SUM_W-ELEMENT_WIDTH){op_raw[ELEMENT_WIDTH-1]}}, op_raw};
      subtract = step.valid & step.subtract;
      sum_next = sum_ff + (subtract ? ~op_ext : op_ext) + SUM_W'(subtract);
      sum_in   = sum_ff;
      if (ctl.clear) begin
         sum_in = '0;
      end else if (ctl.load || step.valid) begin
         sum_in = sum_next;
      end
   end

   // Compare the sum of the current leaf and keep the count and the highest matching leaf.
   always_comb begin
      target_ext   = SUM_W'(target);
      hit          = cmp_valid_ff && (sum_ff == target_ext);
      cmp_valid_in = ctl.start | step.valid;
      cmp_leaf_in  = ctl.start ? '0 : leaf;
      count_in     = count_ff;
      best_in      = best_ff;
      if (ctl.start) begin
         count_in = '0;
         best_in  = '0;
      end else if (hit) begin
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + COUNT_W'(1);
         end
         if ((count_ff == '0) || (cmp_leaf_ff > best_ff)) begin
            best_in = cmp_leaf_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         count_ff     <= '0;
         best_ff      <= '0;
      end else begin
         sum_ff       <= sum_in;
         cmp_valid_ff <= cmp_valid_in;
         count_ff     <= count_in;
         best_ff      <= best_in;
      end
      cmp_leaf_ff <= cmp_leaf_in;
   end

   assign busy        = cmp_valid_ff;
   assign match_count = count_ff;
   assign best_leaf   = best_ff;

endmodule

`default_nettype wire

@@ rtl/subset_sum_counter_top.sv @@
// Element transactions are taken one per cycle while loading; each that fits in the store is
// stored and added into the running sum, and any beyond it sets the overflow flag. A
// transaction with last_element set starts a Gray-code walk over all 2^N subsets of the N
// stored elements, one leaf per cycle through a single shared adder; the result is then
// offered, and no element is taken until it is delivered. Reset (synchronous, active high)
// clears the set, the overflow flag and the target to zero; the element store is not cleared.
`default_nettype none

module subset_sum_counter_top
   import sss_pkg::*;
#(
   parameter int MAX_ELEMENTS  = 16,
   parameter int ELEMENT_WIDTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   sss_req_if.sink                         req_bus,
   sss_rsp_if.source                       rsp_bus,
   input  wire logic                       csr_write_en,
   input  wire logic signed [TARGET_W-1:0] csr_write_data
);

   localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
   localparam int ADDR_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int SUM_RAW = ELEMENT_WIDTH + CNT_W;
   localparam int SUM_W   = (SUM_RAW > TARGET_W) ? SUM_RAW : TARGET_W;
   localparam int RAW_W   = (ELEMENT_WIDTH > ELEM_FIELD_W) ? ELEMENT_WIDTH : ELEM_FIELD_W;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_WALK,
      ST_REPLY
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           elem_count_ff, elem_count_in;
   logic                       overflow_ff, overflow_in;
   logic signed [TARGET_W-1:0] target_ff;
   logic                       found_ff, found_in;
   logic [COUNT_W-1:0]         match_count_ff, match_count_in;
   logic [MASK_W-1:0]          subset_mask_ff, subset_mask_in;
   logic                       rsp_overflow_ff, rsp_overflow_in;

   logic                     req_accept;
   logic                     rsp_accept;
   logic                     store_room;
   logic [RAW_W-1:0]         raw_ext;
   logic [ELEMENT_WIDTH-1:0] elem_value;
   accum_ctl_type            accum_ctl;
   logic                     walk_busy;

   logic [ADDR_W-1:0]        rd_addr;
   logic [ELEMENT_WIDTH-1:0] rd_data;
   logic                     gen_active;
   step_type                 gen_step;
   logic [MAX_ELEMENTS-1:0]  gen_leaf;
   logic                     accum_busy;
   logic [COUNT_W-1:0]       accum_count;
   logic [MAX_ELEMENTS-1:0]  best_leaf;

   // Handshake and element capture; input bits above the element width are ignored.
   always_comb begin
      req_accept = req_bus.valid && (state_ff == ST_LOAD);
      rsp_accept = (state_ff == ST_REPLY) && rsp_bus.ready;
      store_room = (elem_count_ff != CNT_W'(MAX_ELEMENTS));
      raw_ext    = RAW_W'($unsigned(req_bus.element_value));
      elem_value = raw_ext[ELEMENT_WIDTH-1:0];
      accum_ctl.clear = rsp_accept;
      accum_ctl.load  = req_accept && store_room;
      accum_ctl.start = req_accept && req_bus.last_element;
      walk_busy  = gen_active || gen_step.valid || accum_busy;
   end

   sss_elem_store #(
      .DEPTH  (MAX_ELEMENTS),
      .WIDTH  (ELEMENT_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (accum_ctl.load),
      .wr_addr (elem_count_ff[ADDR_W-1:0]),
      .wr_data (elem_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sss_step_gen #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .CNT_W        (CNT_W),
      .ADDR_W       (ADDR_W)
   ) u_step_gen (
      .clock      (clock),
      .reset      (reset),
      .start      (accum_ctl.start),
      .elem_count (elem_count_ff),
      .rd_addr    (rd_addr),
      .active     (gen_active),
      .step       (gen_step),
      .leaf       (gen_leaf)
   );

   sss_accum #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .MAX_ELEMENTS  (MAX_ELEMENTS),
      .SUM_W         (SUM_W)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .ctl         (accum_ctl),
      .load_data   (elem_value),
      .rd_data     (rd_data),
      .step        (gen_step),
      .leaf        (gen_leaf),
      .target      (target_ff),
      .busy        (accum_busy),
      .match_count (accum_count),
      .best_leaf   (best_leaf)
   );

   // Sequencer: load elements, walk the subsets, then hold the result until it is taken.
   always_comb begin
      state_in        = state_ff;
      elem_count_in   = elem_count_ff;
      overflow_in     = overflow_ff;
      found_in        = found_ff;
      match_count_in  = match_count_ff;
      subset_mask_in  = subset_mask_ff;
      rsp_overflow_in = rsp_overflow_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (store_room) begin
                  elem_count_in = elem_count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_bus.last_element) begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (!walk_busy) begin
               found_in        = (accum_count != '0);
               match_count_in  = accum_count;
               rsp_overflow_in = overflow_ff;
               // Leaf bit N-1-k clear means element k is in the subset.
               subset_mask_in  = '0;
               for (int k = 0; k < MASK_W; k++) begin
                  if ((accum_count != '0) && (k < int'(elem_count_ff))) begin
                     subset_mask_in[k] =
                        ~best_leaf[ADDR_W'(int'(elem_count_ff) - 1 - k)];
                  end
               end
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (rsp_accept) begin
               elem_count_in = '0;
               overflow_in   = 1'b0;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         elem_count_ff <= '0;
         overflow_ff   <= 1'b0;
         target_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         elem_count_ff <= elem_count_in;
         overflow_ff   <= overflow_in;
         if (csr_write_en) begin
            target_ff <= csr_write_data;
         end
      end
      found_ff        <= found_in;
      match_count_ff  <= match_count_in;
      subset_mask_ff  <= subset_mask_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   // Port drive.
   assign req_bus.ready       = (state_ff == ST_LOAD);
   assign rsp_bus.valid       = (state_ff == ST_REPLY);
   assign rsp_bus.found       = found_ff;
   assign rsp_bus.match_count = match_count_ff;
   assign rsp_bus.subset_mask = subset_mask_ff;
   assign rsp_bus.overflow    = rsp_overflow_ff;

endmodule

`default_nettype wire

@@ tb/subset_sum_counter_top_test.sv @@
`timescale 1ns / 1ps

module subset_sum_counter_top_test;
   import sss_pkg::*;

   localparam int MAX_ELEMENTS  = 16;
   localparam int ELEMENT_WIDTH = 16;
   localparam int STALL_LIMIT   = 400000;

   // One expected result transaction, field by field.
   typedef struct packed {
      logic               found;
      logic [COUNT_W-1:0] match_count;
      logic [MASK_W-1:0]  subset_mask;
      logic               overflow;
   } subset_result_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic signed [TARGET_W-1:0] csr_write_data;

   sss_req_if req_bus ();
   sss_rsp_if rsp_bus ();

   subset_sum_counter_top #(
      .MAX_ELEMENTS  (MAX_ELEMENTS),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Predictor state: the current set, its overflow flag and the target.
   logic signed [ELEM_FIELD_W-1:0] set_elements [MAX_ELEMENTS];
   int unsigned                    set_size;
   bit                             set_overflow;
   logic signed [TARGET_W-1:0]     model_target;

   subset_result_type pending_results [$];
   subset_result_type checked_result;
   int unsigned       mismatch_count;
   int unsigned       quiet_cycles;

   int send_idle_pct;
   int rsp_stall_pct;
   int hold_off_cycles;

   // Clock with a 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Walk every subset of the current set in leaf order and count exact matches.
   // Element k is included in leaf c when bit (size-1-k) of c is clear, so the
   // last matching leaf gives the reported mask.
   function automatic subset_result_type predict_subset_result();
      subset_result_type res;
      longint            sum;
      logic [MASK_W-1:0] mask;
      int unsigned       leaf;
      int unsigned       k;
      int unsigned       leaves;
      res = '0;
      leaves = 1 << set_size;
      for (leaf = 0; leaf < leaves; leaf++) begin
         sum = 0;
         mask = '0;
         for (k = 0; k < set_size; k++) begin
            if (((leaf >> (set_size - 1 - k)) & 1) == 0) begin
               sum += set_elements[k];
               mask[k] = 1'b1;
            end
         end
         if (sum == longint'(model_target)) begin
            if (res.match_count != COUNT_MAX) res.match_count++;
            res.subset_mask = mask;
         end
      end
      res.found = (res.match_count != 0);
      res.overflow = set_overflow;
      return res;
   endfunction

   // Offer one element transaction, with random idle cycles first, and update
   // the predictor when it is accepted.
   task automatic send_element(input logic signed [ELEM_FIELD_W-1:0] value, input bit last);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.element_value <= value;
      req_bus.last_element  <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (set_size < MAX_ELEMENTS) begin
         set_elements[set_size] = value;
         set_size++;
      end else begin
         set_overflow = 1'b1;
      end
      if (last) begin
         pending_results.push_back(predict_subset_result());
         set_size = 0;
         set_overflow = 1'b0;
      end
   endtask

   // Stop offering and wait until every predicted result has come back.
   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Write the target register once the block has gone idle.
   task automatic write_target(input logic signed [TARGET_W-1:0] target);
      wait_for_results();
      repeat (4) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= target;
      @(negedge clock);
      csr_write_en <= 1'b0;
      model_target = target;
   endtask

   function automatic logic signed [ELEM_FIELD_W-1:0] random_element(input int style);
      logic signed [ELEM_FIELD_W-1:0] value;
      if (style < 5) begin
         value = ELEM_FIELD_W'($urandom_range(0, 6));
         value = value - ELEM_FIELD_W'(3);
      end else if (style < 8) begin
         value = ELEM_FIELD_W'($urandom);
      end else begin
         case ($urandom_range(0, 3))
            0: value = {1'b0, {(ELEM_FIELD_W-1){1'b1}}};
            1: value = {1'b1, {(ELEM_FIELD_W-1){1'b0}}};
            2: value = '0;
            default: value = '1;
         endcase
      end
      return value;
   endfunction

   // Mostly short sets; the full store and overflow only now and then.
   function automatic int unsigned random_set_length();
      int unsigned r;
      r = $urandom_range(0, 199);
      if (r < 150) return $urandom_range(1, 5);
      else if (r < 190) return $urandom_range(6, 10);
      else if (r < 198) return $urandom_range(11, 14);
      else return $urandom_range(15, 18);
   endfunction

   // Build a few sets, pick a target that the first of them can usually reach,
   // then send the sets back to back.
   task automatic send_random_group(output int unsigned items_sent);
      logic signed [ELEM_FIELD_W-1:0] values [$];
      int unsigned                    set_lengths [$];
      int unsigned                    group_sets;
      int unsigned                    len;
      int unsigned                    stored;
      int unsigned                    i;
      int unsigned                    j;
      int unsigned                    pos;
      int                             style;
      int unsigned                    r;
      longint                         pick_sum;
      logic signed [TARGET_W-1:0]     target;
      group_sets = $urandom_range(1, 4);
      for (i = 0; i < group_sets; i++) begin
         len = random_set_length();
         set_lengths.push_back(len);
         style = $urandom_range(0, 9);
         for (j = 0; j < len; j++) values.push_back(random_element(style));
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         pick_sum = 0;
         stored = (set_lengths[0] > MAX_ELEMENTS) ? MAX_ELEMENTS : set_lengths[0];
         for (j = 0; j < stored; j++) begin
            if ($urandom_range(0, 1) == 1) pick_sum += values[j];
         end
         target = TARGET_W'(pick_sum);
      end else if (r < 75) begin
         target = '0;
      end else if (r < 90) begin
         target = TARGET_W'($urandom);
      end else if (r < 95) begin
         target = {1'b1, {(TARGET_W-1){1'b0}}};
      end else begin
         target = {1'b0, {(TARGET_W-1){1'b1}}};
      end
      write_target(target);
      pos = 0;
      for (i = 0; i < group_sets; i++) begin
         for (j = 0; j < set_lengths[i]; j++) begin
            send_element(values[pos], j == set_lengths[i] - 1);
            pos++;
         end
      end
      items_sent = pos;
   endtask

   // Single elements and pairs at the field extremes, both target extremes, and the
   // empty subset matching a zero target.
   task automatic test_directed_sets();
      write_target(TARGET_W'(32767));
      send_element(16'sh7fff, 1'b1);
      write_target(TARGET_W'(-32768));
      send_element(16'sh8000, 1'b1);
      send_element(16'sh5555, 1'b0);
      send_element(16'shaaaa, 1'b1);
      write_target('0);
      send_element(16'sd5, 1'b1);
      send_element(16'sd1, 1'b0);
      send_element(-16'sd1, 1'b0);
      send_element(16'sd0, 1'b1);
      write_target({1'b0, {(TARGET_W-1){1'b1}}});
      send_element(16'sh7fff, 1'b0);
      send_element(16'sh7fff, 1'b1);
      write_target({1'b1, {(TARGET_W-1){1'b0}}});
      send_element(16'sh8000, 1'b0);
      send_element(16'sh8000, 1'b1);
   endtask

   // A full store of zeros gives the largest count; an oversized set drops its
   // tail, including the last element, and the next set starts clean.
   task automatic test_store_limits();
      int unsigned j;
      write_target('0);
      for (j = 0; j < MAX_ELEMENTS; j++) send_element('0, j == MAX_ELEMENTS - 1);
      write_target(TARGET_W'(2));
      for (j = 0; j < MAX_ELEMENTS + 2; j++) send_element(random_element(0), j == MAX_ELEMENTS + 1);
      send_element(16'sd2, 1'b0);
      send_element(16'sd3, 1'b1);
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct, input int quota);
      int unsigned sent;
      int unsigned group_items;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < quota) begin
         send_random_group(group_items);
         sent += group_items;
      end
   endtask

   // Hold the receiver off for a long stretch while short sets keep coming,
   // so the block holds its result and stalls its input; then pause until drained.
   task automatic test_backpressure();
      int unsigned i;
      int unsigned j;
      int unsigned len;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_target(TARGET_W'(1));
      hold_off_cycles = 600;
      for (i = 0; i < 8; i++) begin
         len = $urandom_range(1, 3);
         for (j = 0; j < len; j++) send_element(random_element(0), j == len - 1);
      end
      wait_for_results();
   endtask

   // Result side: ready is driven at the falling edge, with random stalls and
   // an optional long hold-off.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Compare each result transaction with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: found %0d, match_count %0d, subset_mask %h, overflow %0d",
                   rsp_bus.found, rsp_bus.match_count, rsp_bus.subset_mask, rsp_bus.overflow);
            mismatch_count++;
         end else begin
            checked_result = pending_results.pop_front();
            if (rsp_bus.found !== checked_result.found) begin
               $error("found: expected %0d, actual %0d", checked_result.found, rsp_bus.found);
               mismatch_count++;
            end
            if (rsp_bus.match_count !== checked_result.match_count) begin
               $error("match_count: expected %0d, actual %0d",
                      checked_result.match_count, rsp_bus.match_count);
               mismatch_count++;
            end
            if (rsp_bus.subset_mask !== checked_result.subset_mask) begin
               $error("subset_mask: expected %h, actual %h",
                      checked_result.subset_mask, rsp_bus.subset_mask);
               mismatch_count++;
            end
            if (rsp_bus.overflow !== checked_result.overflow) begin
               $error("overflow: expected %0d, actual %0d",
                      checked_result.overflow, rsp_bus.overflow);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no transaction has moved for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                 = 1'b1;
      csr_write_en          = 1'b0;
      csr_write_data        = '0;
      req_bus.valid         = 1'b0;
      req_bus.element_value = '0;
      req_bus.last_element  = 1'b0;
      set_size              = 0;
      set_overflow          = 1'b0;
      model_target          = '0;
      mismatch_count        = 0;
      quiet_cycles          = 0;
      send_idle_pct         = 0;
      rsp_stall_pct         = 0;
      hold_off_cycles       = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_sets();
      test_store_limits();
      test_random_phase(0, 0, 375);
      test_random_phase(78, 0, 375);
      test_random_phase(0, 78, 375);
      test_random_phase(31, 31, 375);
      test_backpressure();

      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/sss_pkg.sv
rtl/sss_req_if.sv
rtl/sss_rsp_if.sv
rtl/sss_elem_store.sv
rtl/sss_step_gen.sv
rtl/sss_accum.sv
rtl/subset_sum_counter_top.sv
tb/subset_sum_counter_top_test.sv
